@@ sv/phsc_pkg.sv @@
package phsc_pkg;

    localparam int REG_W = 5;
    localparam int CNT_W = 3;

    // Each transaction ticks the counters at least once and every counter tops
    // out at 7. So a write older than seven transactions reads as zero.
    localparam int SB_DEPTH = 7;

    localparam logic [CNT_W-1:0] DIRTY_STAGES  = 3'd3;
    localparam logic [CNT_W-1:0] ALU_FWD_LIMIT = 3'd2;
    localparam logic [CNT_W-1:0] STALL_MAX     = 3'd7;
    localparam logic [1:0]       MISPREDICT_BUBBLES = 2'd2;

    // forwarding_mode codes (3 behaves as full)
    localparam logic [1:0] FWD_NONE = 2'd0;
    localparam logic [1:0] FWD_ALU  = 2'd1;
    localparam logic [1:0] FWD_FULL = 2'd2;

    // branch_prediction codes
    localparam logic [1:0] BP_NONE      = 2'd0;
    localparam logic [1:0] BP_PERFECT   = 2'd1;
    localparam logic [1:0] BP_TAKEN     = 2'd2;
    localparam logic [1:0] BP_NOT_TAKEN = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FWD_MODE  = 2'd0;
    localparam logic [1:0] CFG_BR_PRED   = 2'd1;
    localparam logic [1:0] CFG_BR_DECODE = 2'd2;

    typedef struct packed {
        logic [REG_W-1:0] src_a;
        logic [2:0]       src_a_need;
        logic [REG_W-1:0] src_b;
        logic [2:0]       src_b_need;
        logic             dest_valid;
        logic [REG_W-1:0] dest_reg;
        logic [CNT_W-1:0] result_ready;
        logic             is_branch;
        logic             branch_taken;
    } phsc_in_t;

    typedef struct packed {
        logic [2:0] stall_count;
        logic [1:0] bubble_count;
    } phsc_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] busy;
        logic [CNT_W-1:0] dirty;
    } phsc_cnt_t;

endpackage

@@ sv/pipeline_hazard_stall_counter_core.sv @@
// Result: valid after S stalled issue attempts and one that issues, S = stall count.
//   Counters peak at 7 and tick before each check, so S is 0..6.
//   Each issue attempt is tick, check source A, check source B.
// A new transaction is taken only in idle, after the last one has issued; one shared hazard-check unit.
// Reset (rst_n, async, active low): sequencer idle, scoreboard empty, config zero,
//   last-was-stall clear, no result pending.
module pipeline_hazard_stall_counter_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  phsc_pkg::phsc_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output phsc_pkg::phsc_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [1:0]          cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;  // age every counter by one
    localparam logic [2:0] ST_CHK_A = 3'd2;  // check source A
    localparam logic [2:0] ST_CHK_B = 3'd3;  // check source B, stall or go on
    localparam logic [2:0] ST_FIN   = 3'd4;  // issue: bubbles, dest write, result

    logic [2:0]          state_reg, state_next;
    phsc_pkg::phsc_in_t  item_reg;
    logic [2:0]          stalls_reg, stalls_next;
    logic                lws_reg, lws_next;
    logic                haz_a_reg, haz_a_next;
    logic                out_valid_reg, out_valid_next;
    phsc_pkg::phsc_out_t out_reg, out_next;

    // configuration
    logic [1:0] fwd_mode_reg;
    logic [1:0] br_pred_reg;
    logic       br_decode_reg;

    // shared check path
    logic [phsc_pkg::REG_W-1:0] chk_reg_sel;
    logic [2:0]                 chk_need_sel;
    phsc_pkg::phsc_cnt_t        chk_cnt;
    logic                       chk_hazard;

    logic                in_fire;
    logic                fin_go;
    logic [1:0]          full_penalty;
    logic [1:0]          bubbles;
    phsc_pkg::phsc_cnt_t push_cnt;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // result slot must be free (or draining) before the final step
    assign fin_go = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_mode_reg  <= phsc_pkg::FWD_NONE;
            br_pred_reg   <= phsc_pkg::BP_NONE;
            br_decode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                phsc_pkg::CFG_FWD_MODE:  fwd_mode_reg  <= cfg_data;
                phsc_pkg::CFG_BR_PRED:   br_pred_reg   <= cfg_data;
                phsc_pkg::CFG_BR_DECODE: br_decode_reg <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // one source per cycle through the shared lookup and hazard rule
    assign chk_reg_sel  = (state_reg == ST_CHK_A) ? item_reg.src_a : item_reg.src_b;
    assign chk_need_sel = (state_reg == ST_CHK_A) ? item_reg.src_a_need
                                                  : item_reg.src_b_need;

    assign push_cnt.busy  = item_reg.result_ready;
    assign push_cnt.dirty = phsc_pkg::DIRTY_STAGES;

    phsc_scoreboard u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (state_reg == ST_TICK),
        .push       (state_reg == ST_FIN && fin_go),
        .push_valid (item_reg.dest_valid && !item_reg.is_branch),
        .push_reg   (item_reg.dest_reg),
        .push_cnt   (push_cnt),
        .lookup_reg (chk_reg_sel),
        .lookup_cnt (chk_cnt)
    );

    phsc_hazard_unit u_hazard (
        .fwd_mode       (fwd_mode_reg),
        .last_was_stall (lws_reg),
        .src_reg        (chk_reg_sel),
        .src_need       (chk_need_sel),
        .cnt            (chk_cnt),
        .hazard         (chk_hazard)
    );

    // branch bubbles
    assign full_penalty = br_decode_reg ? (phsc_pkg::MISPREDICT_BUBBLES - 2'd1)
                                        : phsc_pkg::MISPREDICT_BUBBLES;

    always_comb
    begin
        bubbles = 2'd0;
        if (item_reg.is_branch)
        begin
            unique case (br_pred_reg)
                phsc_pkg::BP_NONE:      bubbles = full_penalty;
                phsc_pkg::BP_PERFECT:   bubbles = 2'd0;
                phsc_pkg::BP_TAKEN:     bubbles = item_reg.branch_taken ? 2'd0 : full_penalty;
                phsc_pkg::BP_NOT_TAKEN: bubbles = item_reg.branch_taken ? full_penalty : 2'd0;
                default:                bubbles = 2'd0;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        stalls_next    = stalls_reg;
        lws_next       = lws_reg;
        haz_a_next     = haz_a_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    stalls_next = '0;
                    state_next  = ST_TICK;
                end
            end
            ST_TICK:
            begin
                state_next = ST_CHK_A;
            end
            ST_CHK_A:
            begin
                haz_a_next = chk_hazard;
                state_next = ST_CHK_B;
            end
            ST_CHK_B:
            begin
                if (haz_a_reg || chk_hazard)
                begin
                    // stall: count it (saturating) and retry after another tick
                    if (stalls_reg != phsc_pkg::STALL_MAX)
                    begin
                        stalls_next = stalls_reg + 3'd1;
                    end
                    lws_next   = 1'b1;
                    state_next = ST_TICK;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    lws_next              = 1'b0;
                    out_valid_next        = 1'b1;
                    out_next.stall_count  = stalls_reg;
                    out_next.bubble_count = bubbles;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stalls_reg    <= '0;
            lws_reg       <= 1'b0;
            haz_a_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stalls_reg    <= stalls_next;
            lws_reg       <= lws_next;
            haz_a_reg     <= haz_a_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        out_reg <= out_next;
    end

    // an accepted transaction always starts with a counter tick
    a_accept_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_TICK)
        else $error("accepted transaction did not start with a tick");

    // each tick is followed by the source A check
    a_tick_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK |=> state_reg == ST_CHK_A)
        else $error("tick not followed by source A check");

    // the stall flag mirrors whether this transaction has stalled yet
    a_stall_flag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK |-> lws_reg == (stalls_reg != 3'd0))
        else $error("last-was-stall flag out of step with stall count");

    // a new result only comes out of the issue step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the issue step");

endmodule

@@ sv/phsc_scoreboard.sv @@
// Recent-write queue: newest entry at index 0, all counters age on tick.
module phsc_scoreboard (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick,
    input  logic                      push,
    input  logic                      push_valid,
    input  logic [phsc_pkg::REG_W-1:0] push_reg,
    input  phsc_pkg::phsc_cnt_t       push_cnt,
    input  logic [phsc_pkg::REG_W-1:0] lookup_reg,
    output phsc_pkg::phsc_cnt_t       lookup_cnt
);

    logic [phsc_pkg::SB_DEPTH-1:0] valid_reg;
    logic [phsc_pkg::REG_W-1:0]    tag_reg [phsc_pkg::SB_DEPTH];
    phsc_pkg::phsc_cnt_t           cnt_reg [phsc_pkg::SB_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (push)
        begin
            valid_reg <= {valid_reg[phsc_pkg::SB_DEPTH-2:0], push_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tag_reg[0] <= push_reg;
            cnt_reg[0] <= push_cnt;
            for (int i = 1; i < phsc_pkg::SB_DEPTH; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
                cnt_reg[i] <= cnt_reg[i-1];
            end
        end
        else if (tick)
        begin
            for (int i = 0; i < phsc_pkg::SB_DEPTH; i++)
            begin
                if (cnt_reg[i].busy != '0)
                begin
                    cnt_reg[i].busy <= cnt_reg[i].busy - 1'b1;
                end
                if (cnt_reg[i].dirty != '0)
                begin
                    cnt_reg[i].dirty <= cnt_reg[i].dirty - 1'b1;
                end
            end
        end
    end

    // newest matching entry wins; no match reads as idle
    always_comb
    begin
        lookup_cnt = '0;
        for (int i = phsc_pkg::SB_DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == lookup_reg)
            begin
                lookup_cnt = cnt_reg[i];
            end
        end
    end

endmodule

@@ sv/phsc_hazard_unit.sv @@
// Hazard rule for one source operand, shared by both sources.
module phsc_hazard_unit (
    input  logic [1:0]                 fwd_mode,
    input  logic                       last_was_stall,
    input  logic [phsc_pkg::REG_W-1:0] src_reg,
    input  logic [2:0]                 src_need,
    input  phsc_pkg::phsc_cnt_t        cnt,
    output logic                       hazard
);

    always_comb
    begin
        hazard = 1'b0;
        if (src_need != '0 && src_reg != '0)
        begin
            case (fwd_mode)
                phsc_pkg::FWD_NONE:
                begin
                    hazard = (cnt.dirty != '0);
                end
                phsc_pkg::FWD_ALU:
                begin
                    hazard = (cnt.busy > phsc_pkg::ALU_FWD_LIMIT) ||
                             (last_was_stall && cnt.dirty != '0);
                end
                default:
                begin
                    hazard = (cnt.busy >= src_need);
                end
            endcase
        end
    end

endmodule
